[design/mshc_pkg.sv]
package mshc_pkg;

  // Field widths
  localparam int KEY_W  = 17;
  localparam int DATA_W = 32;

  // Home bucket geometry
  localparam int HOME_BUCKETS = 10;
  localparam int HOME_W       = 4;

  // Default size of the shared overflow store
  localparam int OVERFLOW_SLOTS_DEF = 128;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [HOME_W-1:0] home_t;
  typedef logic [1:0]        status_t;

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Result status codes
  localparam status_t ST_INSERTED = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_FOUND    = 2'd2;
  localparam status_t ST_MISSING  = 2'd3;

  typedef struct packed {
    logic  req_type;
    key_t  key;
    data_t data;
  } in_item_t;

  typedef struct packed {
    status_t status;
    data_t   found_data;
  } out_item_t;

endpackage

[design/midsquare_hash_table_chained.sv]
// Channel | Ports                          | Payload
// --------+--------------------------------+--------------------------------
// input   | in_valid, in_ready, in_item    | req_type, key, data
// output  | out_valid, out_ready, out_item | status, found_data
//
// One request at a time. Hashing comes first, then the bucket RAM read and one
// step per overflow node visited; the result goes out straight after hashing when
// the home bucket is empty or an insert finds the overflow store full. in_ready
// rises as the result enters the output register, with out_valid if that was idle.
// Reset (rst_n low, synchronous) clears the bucket-used bits and fill count.
// A stalled output holds its result until transferred; the next request is taken
// and, once finished, waits in the sequencer for the output register.
module midsquare_hash_table_chained #(
  parameter int OVERFLOW_SLOTS = mshc_pkg::OVERFLOW_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mshc_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output mshc_pkg::out_item_t out_item
);
  import mshc_pkg::*;

  localparam int LW = $clog2(OVERFLOW_SLOTS + 1);
  localparam int SW = (OVERFLOW_SLOTS > 1) ? $clog2(OVERFLOW_SLOTS) : 1;

  // Link coding: 0 ends the chain, n points at overflow slot n-1
  typedef logic [LW-1:0] link_t;

  typedef struct packed {
    key_t  key;
    data_t value;
    link_t next;
  } entry_t;

  localparam int EW = $bits(entry_t);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_BCHK = 3'd2;
  localparam logic [2:0] S_SCHK = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic                    req_r, req_nxt;
  key_t                    key_r, key_nxt;
  data_t                   data_r, data_nxt;
  home_t                   home_r, home_nxt;
  logic [HOME_BUCKETS-1:0] used_r, used_nxt;
  link_t                   fill_r, fill_nxt;
  link_t                   new_link_r, new_link_nxt;
  link_t                   cur_r, cur_nxt;
  status_t                 status_r, status_nxt;
  data_t                   found_r, found_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r, out_item_nxt;

  logic    hash_start;
  logic    hash_done;
  home_t   hash_home;

  logic          b_we;
  home_t         b_waddr, b_raddr;
  entry_t        b_wdata;
  logic [EW-1:0] b_rdata;
  logic          s_we;
  logic [SW-1:0] s_waddr, s_raddr;
  entry_t        s_wdata;
  logic [EW-1:0] s_rdata;

  entry_t bent, sent;
  link_t  bnext_m1, snext_m1, cur_m1;

  assign in_ready   = (state_r == S_IDLE);
  assign hash_start = in_valid && in_ready;

  mshc_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key_in(in_item.key),
    .done  (hash_done),
    .home  (hash_home)
  );

  mshc_ram #(.WIDTH(EW), .DEPTH(HOME_BUCKETS)) u_bucket_ram (
    .clk  (clk),
    .we   (b_we),
    .waddr(b_waddr),
    .wdata(b_wdata),
    .raddr(b_raddr),
    .rdata(b_rdata)
  );

  mshc_ram #(.WIDTH(EW), .DEPTH(OVERFLOW_SLOTS)) u_spill_ram (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  assign bent     = entry_t'(b_rdata);
  assign sent     = entry_t'(s_rdata);
  assign bnext_m1 = bent.next - link_t'(1);
  assign snext_m1 = sent.next - link_t'(1);
  assign cur_m1   = cur_r - link_t'(1);

  // Request sequencer: hash, then walk the chain one node per cycle.
  // Writes never target an entry that a pending read depends on: a new slot
  // is unlinked until the tail rewrite, which ends the item.
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    key_nxt       = key_r;
    data_nxt      = data_r;
    home_nxt      = home_r;
    used_nxt      = used_r;
    fill_nxt      = fill_r;
    new_link_nxt  = new_link_r;
    cur_nxt       = cur_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;

    b_we    = 1'b0;
    b_waddr = home_r;
    b_wdata = '{key: key_r, value: data_r, next: '0};
    b_raddr = hash_home;
    s_we    = 1'b0;
    s_waddr = fill_r[SW-1:0];
    s_wdata = '{key: key_r, value: data_r, next: '0};
    s_raddr = bnext_m1[SW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_item.req_type;
          key_nxt   = in_item.key;
          data_nxt  = in_item.data;
          state_nxt = S_HASH;
        end
      end

      S_HASH: begin
        if (hash_done) begin
          home_nxt  = hash_home;
          found_nxt = '0;
          if (req_r == REQ_INSERT) begin
            if (!used_r[hash_home]) begin
              // Empty home bucket: fill it directly
              b_we                = 1'b1;
              b_waddr             = hash_home;
              used_nxt[hash_home] = 1'b1;
              status_nxt          = ST_INSERTED;
              state_nxt           = S_RESP;
            end else if (fill_r >= link_t'(OVERFLOW_SLOTS)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_RESP;
            end else begin
              // Claim the next overflow slot, then find the chain tail
              s_we         = 1'b1;
              fill_nxt     = fill_r + link_t'(1);
              new_link_nxt = fill_r + link_t'(1);
              state_nxt    = S_BCHK;
            end
          end else begin
            if (!used_r[hash_home]) begin
              status_nxt = ST_MISSING;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_BCHK;
            end
          end
        end
      end

      S_BCHK: begin
        if (req_r == REQ_SEARCH && bent.key == key_r) begin
          status_nxt = ST_FOUND;
          found_nxt  = bent.value;
          state_nxt  = S_RESP;
        end else if (bent.next == '0) begin
          if (req_r == REQ_INSERT) begin
            // Bucket is the tail: link the new slot here
            b_we       = 1'b1;
            b_wdata    = '{key: bent.key, value: bent.value, next: new_link_r};
            status_nxt = ST_INSERTED;
          end else begin
            status_nxt = ST_MISSING;
          end
          state_nxt = S_RESP;
        end else begin
          s_raddr   = bnext_m1[SW-1:0];
          cur_nxt   = bent.next;
          state_nxt = S_SCHK;
        end
      end

      S_SCHK: begin
        if (req_r == REQ_SEARCH && sent.key == key_r) begin
          status_nxt = ST_FOUND;
          found_nxt  = sent.value;
          state_nxt  = S_RESP;
        end else if (sent.next == '0) begin
          if (req_r == REQ_INSERT) begin
            // Slot is the tail: rewrite it with the new link
            s_we       = 1'b1;
            s_waddr    = cur_m1[SW-1:0];
            s_wdata    = '{key: sent.key, value: sent.value, next: new_link_r};
            status_nxt = ST_INSERTED;
          end else begin
            status_nxt = ST_MISSING;
          end
          state_nxt = S_RESP;
        end else begin
          s_raddr = snext_m1[SW-1:0];
          cur_nxt = sent.next;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.status     = status_r;
          out_item_nxt.found_data = found_r;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    data_r     <= data_nxt;
    home_r     <= home_nxt;
    new_link_r <= new_link_nxt;
    cur_r      <= cur_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[design/mshc_ram.sv]
module mshc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/mshc_hash.sv]
module mshc_hash (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  mshc_pkg::key_t key_in,
  output logic           done,
  output mshc_pkg::home_t home
);
  import mshc_pkg::*;

  // Home bucket = hundreds digit of ((key mod 1000)^2 mod 1000).
  // Each mod 1000 uses a reciprocal multiply; the digit uses x*41 >> 12.
  localparam int          Shift1   = 27;
  localparam logic [17:0] Recip1   = 18'd134218;
  localparam int          Shift2   = 30;
  localparam logic [20:0] Recip2   = 21'd1073742;
  localparam logic [9:0]  Thousand = 10'd1000;
  localparam logic [5:0]  DigitMul = 6'd41;
  localparam int          DigitSh  = 12;
  localparam int          Stages   = 6;

  logic [Stages-1:0] v_r;
  key_t              key1_r;
  logic [7:0]        q1_r;
  logic [9:0]        r1_r;
  logic [19:0]       sq_r;
  logic [19:0]       sq4_r;
  logic [9:0]        q2_r;
  logic [9:0]        r2_r;
  home_t             home_r;

  logic [34:0] prod1;
  logic [17:0] diff1;
  logic [40:0] prod2;
  logic [19:0] diff2;
  logic [15:0] prod3;

  assign prod1 = 35'(key_in) * 35'(Recip1);
  assign diff1 = 18'(key1_r) - 18'(q1_r) * 18'(Thousand);
  assign prod2 = 41'(sq_r) * 41'(Recip2);
  assign diff2 = sq4_r - 20'(q2_r) * 20'(Thousand);
  assign prod3 = 16'(r2_r) * 16'(DigitMul);

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[Stages-2:0], start};
    end
  end

  // Datapath stages, one multiply each
  always_ff @(posedge clk) begin
    key1_r <= key_in;
    q1_r   <= prod1[Shift1 +: 8];
    r1_r   <= diff1[9:0];
    sq_r   <= 20'(r1_r) * 20'(r1_r);
    q2_r   <= prod2[Shift2 +: 10];
    sq4_r  <= sq_r;
    r2_r   <= diff2[9:0];
    home_r <= prod3[DigitSh +: HOME_W];
  end

  assign done = v_r[Stages-1];
  assign home = home_r;

endmodule

[design/mshc_chk.sv]
module mshc_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input mshc_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input mshc_pkg::out_item_t out_item
);
  import mshc_pkg::*;

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  // Data is reported only with a hit
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_FOUND |-> out_item.found_data == '0)
    else $error("found_data nonzero without a hit");

  // One request in flight: no back-to-back input transfers
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a request is in progress");

  // Hashing latency: no result can appear right after a transfer
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared before the hash completed");

endmodule

bind midsquare_hash_table_chained mshc_chk u_chk (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import mshc_pkg::*;

  localparam int SLOTS      = OVERFLOW_SLOTS_DEF;
  localparam int RAND_ITEMS = 1280;
  localparam int LONG_HOLD  = 300;
  // Worst result latency: hashing plus a walk over every overflow node
  localparam int DRAIN      = 9 + SLOTS + 20;
  // Bucket kept empty until the overflow store is exhausted
  localparam int SPARE_HOME = 7;

  typedef struct {
    bit        pinned;
    out_item_t val;
  } pin_t;

  typedef struct {
    logic      req;
    key_t      key;
    data_t     data;
    bit        pinned;
    status_t   st;
    data_t     fd;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  // Shadow copy of the table
  bit          bucket_used [HOME_BUCKETS];
  key_t        bucket_key  [HOME_BUCKETS];
  data_t       bucket_value[HOME_BUCKETS];
  int unsigned bucket_next [HOME_BUCKETS];
  key_t        spill_key   [SLOTS];
  data_t       spill_value [SLOTS];
  int unsigned spill_next  [SLOTS];
  int unsigned slot_fill;

  out_item_t pending_results[$];
  pin_t      offered_pins[$];
  dir_row_t  dir_rows[$];
  key_t      keys_stored[$];

  int errors;
  int results_seen;
  int n_stored, n_dropped, n_hit, n_miss;
  int max_hold;

  midsquare_hash_table_chained i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Third decimal digit of the exact square
  function automatic int unsigned home_bucket(key_t k);
    longint unsigned kk;
    longint unsigned sq;
    kk = k;
    sq = kk * kk;
    return int'((sq / 100) % 10);
  endfunction

  function automatic bit link_live(int unsigned l);
    return l != 0 && l <= slot_fill && l <= SLOTS;
  endfunction

  // Apply one request to the shadow table and return its result
  function automatic out_item_t table_apply(in_item_t it);
    out_item_t   r;
    int unsigned h;
    int unsigned link;
    int unsigned slot;
    int unsigned steps;
    r.status     = ST_MISSING;
    r.found_data = '0;
    h = home_bucket(it.key);
    if (it.req_type == REQ_INSERT) begin
      if (!bucket_used[h]) begin
        bucket_used[h]  = 1'b1;
        bucket_key[h]   = it.key;
        bucket_value[h] = it.data;
        bucket_next[h]  = 0;
        r.status = ST_INSERTED;
      end else if (slot_fill >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        slot = slot_fill;
        spill_key[slot]   = it.key;
        spill_value[slot] = it.data;
        spill_next[slot]  = 0;
        if (!link_live(bucket_next[h])) begin
          bucket_next[h] = slot + 1;
        end else begin
          // append at the tail of the chain
          link = bucket_next[h];
          for (steps = 0; steps < SLOTS; steps++) begin
            if (!link_live(spill_next[link-1])) break;
            link = spill_next[link-1];
          end
          spill_next[link-1] = slot + 1;
        end
        slot_fill = slot + 1;
        r.status  = ST_INSERTED;
      end
    end else if (bucket_used[h]) begin
      if (bucket_key[h] == it.key) begin
        r.status     = ST_FOUND;
        r.found_data = bucket_value[h];
      end else begin
        link = bucket_next[h];
        for (steps = 0; steps < SLOTS && link_live(link); steps++) begin
          if (spill_key[link-1] == it.key) begin
            r.status     = ST_FOUND;
            r.found_data = spill_value[link-1];
            break;
          end
          link = spill_next[link-1];
        end
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_row(logic req, key_t key, data_t data, bit pinned,
                         status_t st, data_t fd);
    dir_row_t row;
    row.req    = req;
    row.key    = key;
    row.data   = data;
    row.pinned = pinned;
    row.st     = st;
    row.fd     = fd;
    dir_rows.push_back(row);
  endtask

  // Offer one request after an idle gap and wait for its transfer
  task automatic offer_item(in_item_t it, bit pinned, out_item_t want, int gap);
    pin_t p;
    p.pinned = pinned;
    p.val    = want;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offered_pins.push_back(p);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Predict on input transfer, check on output transfer
  always @(posedge clk) begin
    pin_t      p;
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        p    = offered_pins.pop_front();
        want = table_apply(in_item);
        if (p.pinned) want = p.val;
        pending_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status %0d data %h", $time,
                   out_item.status, out_item.found_data);
        end else begin
          want = pending_results.pop_front();
          case (want.status)
            ST_INSERTED: n_stored++;
            ST_FULL:     n_dropped++;
            ST_FOUND:    n_hit++;
            default:     n_miss++;
          endcase
          if (out_item.status !== want.status) begin
            errors++;
            if (errors <= 200)
              $display("%0t: status mismatch, expected %0d actual %0d", $time,
                       want.status, out_item.status);
          end
          if (out_item.found_data !== want.found_data) begin
            errors++;
            if (errors <= 200)
              $display("%0t: found_data mismatch, expected %h actual %h", $time,
                       want.found_data, out_item.found_data);
          end
        end
      end
    end
  end

  // Result side: random stalls, bursts, and one long hold-off
  initial begin
    int r;
    int n;
    bit long_done;
    long_done = 1'b0;
    max_hold  = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!long_done && results_seen >= 400) begin
        // back up the block so that it stalls its input
        long_done = 1'b1;
        max_hold  = LONG_HOLD;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 60) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(60, 150)) @(posedge clk);
        end else if (r < 95) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          n = $urandom_range(10, 60);
          if (n > max_hold) max_hold = n;
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #15_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Request side: directed table, then random traffic
  initial begin
    in_item_t  it;
    out_item_t want;
    dir_row_t  row;
    int        i;
    int        r;
    bit        reserve;
    clk          = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_item      <= '0;
    errors       = 0;
    results_seen = 0;
    n_stored     = 0;
    n_dropped    = 0;
    n_hit        = 0;
    n_miss       = 0;
    slot_fill    = 0;
    foreach (bucket_used[j]) begin
      bucket_used[j] = 1'b0;
      bucket_next[j] = 0;
    end

    // Empty table, chaining in bucket zero, duplicates, extreme keys and data
    add_row(REQ_SEARCH, 17'd0,      32'h0,        1, ST_MISSING,  32'h0);
    add_row(REQ_INSERT, 17'd0,      32'h0,        1, ST_INSERTED, 32'h0);
    add_row(REQ_SEARCH, 17'd0,      32'hFFFFFFFF, 1, ST_FOUND,    32'h0);
    add_row(REQ_INSERT, 17'd99999,  32'h7FFFFFFF, 1, ST_INSERTED, 32'h0);
    add_row(REQ_INSERT, 17'h1FFFF,  32'h80000000, 1, ST_INSERTED, 32'h0);
    add_row(REQ_SEARCH, 17'd99999,  32'h0,        1, ST_FOUND,    32'h7FFFFFFF);
    add_row(REQ_SEARCH, 17'h1FFFF,  32'h0,        1, ST_FOUND,    32'h80000000);
    add_row(REQ_INSERT, 17'd0,      32'hFFFFFFFF, 1, ST_INSERTED, 32'h0);
    add_row(REQ_SEARCH, 17'd0,      32'h0,        1, ST_FOUND,    32'h0);
    add_row(REQ_SEARCH, 17'd1,      32'h0,        1, ST_MISSING,  32'h0);
    add_row(REQ_SEARCH, 17'd10,     32'h0,        1, ST_MISSING,  32'h0);
    add_row(REQ_INSERT, 17'd99999,  32'h12345678, 0, ST_INSERTED, 32'h0);
    add_row(REQ_SEARCH, 17'd99999,  32'h0,        0, ST_FOUND,    32'h0);
    add_row(REQ_INSERT, 17'd10,     32'hA5A5A5A5, 0, ST_INSERTED, 32'h0);
    add_row(REQ_SEARCH, 17'd10,     32'hFFFFFFFF, 0, ST_FOUND,    32'h0);
    add_row(REQ_INSERT, 17'h10000,  32'h00000001, 0, ST_INSERTED, 32'h0);
    add_row(REQ_SEARCH, 17'h10000,  32'h0,        0, ST_FOUND,    32'h0);
    add_row(REQ_INSERT, 17'd1,      32'h80000001, 0, ST_INSERTED, 32'h0);
    add_row(REQ_SEARCH, 17'd1,      32'h0,        0, ST_FOUND,    32'h0);
    add_row(REQ_INSERT, 17'd99998,  32'h5A5A5A5A, 0, ST_INSERTED, 32'h0);
    add_row(REQ_SEARCH, 17'd12345,  32'h0,        0, ST_MISSING,  32'h0);
    add_row(REQ_SEARCH, 17'd99998,  32'h0,        0, ST_FOUND,    32'h0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[j]) begin
      row = dir_rows[j];
      it.req_type     = row.req;
      it.key          = row.key;
      it.data         = row.data;
      want.status     = row.st;
      want.found_data = row.fd;
      if (row.req == REQ_INSERT) keys_stored.push_back(row.key);
      offer_item(it, row.pinned, want, pick_gap());
    end

    // Insert-heavy at first to exhaust the overflow store, then search-heavy
    want = '0;
    for (i = 0; i < RAND_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      it.req_type = (r < (i < 250 ? 65 : 35)) ? REQ_INSERT : REQ_SEARCH;
      it.data     = $urandom();
      // keep one bucket empty until the store is full
      reserve = !bucket_used[SPARE_HOME] && slot_fill < SLOTS;
      do begin
        r = $urandom_range(0, 99);
        if (r < 45 && keys_stored.size() != 0)
          it.key = keys_stored[$urandom_range(0, keys_stored.size() - 1)];
        else if (r < 85)
          it.key = key_t'($urandom_range(0, 99999));
        else
          it.key = key_t'($urandom_range(0, 131071));
      end while (reserve && home_bucket(it.key) == SPARE_HOME);
      if (it.req_type == REQ_INSERT) keys_stored.push_back(it.key);
      offer_item(it, 1'b0, want, ((i % 256) < 40) ? 0 : pick_gap());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Covered %0d requests: %0d stored, %0d dropped on a full store,",
             results_seen, n_stored, n_dropped);
    $display("%0d hits, %0d misses; overflow store reached %0d of %0d slots",
             n_hit, n_miss, slot_fill, SLOTS);
    $display("Longest output stall %0d cycles", max_hold);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
design/mshc_pkg.sv
design/mshc_ram.sv
design/mshc_hash.sv
design/midsquare_hash_table_chained.sv
design/mshc_chk.sv
tb/testbench.sv
